FILE: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// shared widths, register indexes and calibration types for the barometric
// pressure compensation pipeline
// ----------------------------------------------------------------------------
package bpc_pkg;

  // pipeline depth, one valid bit per stage
  localparam int NUM_STAGES = 6;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 3;
  localparam int COEFF_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_SENS = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SENS_TEMP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REF_TEMP = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_SLOPE = 3'd5;

  // payload widths
  localparam int RAW_W = 24;
  localparam int TEMP_W = 19;
  localparam int PRESS_W = 22;

  // internal widths
  localparam int DT_W = RAW_W + 1;           // raw minus reference, signed
  localparam int PROD_W = DT_W + COEFF_W + 1; // dt times a 16-bit word
  localparam int OFF_W = 37;
  localparam int SENS_W = 36;
  localparam int SENS_LO_W = 17;
  localparam int SENS_HI_W = SENS_W - SENS_LO_W;
  localparam int PP_LO_W = RAW_W + SENS_LO_W;
  localparam int PP_HI_W = RAW_W + 1 + SENS_HI_W;
  localparam int FULL_W = PP_HI_W + SENS_LO_W + 1;
  localparam int PSH_W = FULL_W - 21;
  localparam int DIFF_W = PSH_W + 1;

  // formula constants
  localparam int TEMP_SHIFT = 23;
  localparam int REF_SHIFT = 8;
  localparam int OFF_BASE_SHIFT = 16;
  localparam int OFF_TC_SHIFT = 7;
  localparam int SENS_BASE_SHIFT = 15;
  localparam int SENS_TC_SHIFT = 8;
  localparam int PRESS_MUL_SHIFT = 21;
  localparam int PRESS_OUT_SHIFT = 15;
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] offset;
    logic [COEFF_W-1:0] sens_temp;
    logic [COEFF_W-1:0] offset_temp;
    logic [COEFF_W-1:0] ref_temp;
    logic [COEFF_W-1:0] temp_slope;
  } coeff_t;

endpackage

FILE: hw/rtl/bpc_regs.sv
// ----------------------------------------------------------------------------
// bpc_regs
// apb register file holding the six calibration words
// ----------------------------------------------------------------------------
module bpc_regs import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output coeff_t            coeff
);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  logic [COEFF_W-1:0]   rd_val;

  assign idx = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SENS:        coeff.sens <= pwdata[COEFF_W-1:0];
        REG_OFFSET:      coeff.offset <= pwdata[COEFF_W-1:0];
        REG_SENS_TEMP:   coeff.sens_temp <= pwdata[COEFF_W-1:0];
        REG_OFFSET_TEMP: coeff.offset_temp <= pwdata[COEFF_W-1:0];
        REG_REF_TEMP:    coeff.ref_temp <= pwdata[COEFF_W-1:0];
        REG_TEMP_SLOPE:  coeff.temp_slope <= pwdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SENS:        rd_val = coeff.sens;
      REG_OFFSET:      rd_val = coeff.offset;
      REG_SENS_TEMP:   rd_val = coeff.sens_temp;
      REG_OFFSET_TEMP: rd_val = coeff.offset_temp;
      REG_REF_TEMP:    rd_val = coeff.ref_temp;
      REG_TEMP_SLOPE:  rd_val = coeff.temp_slope;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = {{(DATA_W-COEFF_W){1'b0}}, rd_val};

endmodule

FILE: hw/rtl/bpc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// bpc_pipe_ctrl
// per-stage valid bits and load enables; a stage loads when empty or when
// the stage after it moves on
// ----------------------------------------------------------------------------
module bpc_pipe_ctrl import bpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [NUM_STAGES-1:0] en
);

  logic [NUM_STAGES-1:0] valid;

  always_comb begin
    en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign in_stall = !en[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

FILE: hw/rtl/bpc_datapath.sv
// ----------------------------------------------------------------------------
// bpc_datapath
// six-stage arithmetic: reference subtract, coefficient products, offset and
// sensitivity sums, split pressure products, recombine, final subtract
// ----------------------------------------------------------------------------
module bpc_datapath import bpc_pkg::*; (
  input  logic                      clk,
  input  logic [NUM_STAGES-1:0]     en,
  input  coeff_t                    coeff,
  input  logic [RAW_W-1:0]          raw_temperature,
  input  logic [RAW_W-1:0]          pressure_adc,
  output logic signed [TEMP_W-1:0]  temperature_centi,
  output logic signed [PRESS_W-1:0] pressure_pa
);

  // stage 1
  logic signed [DT_W-1:0]    s1_dt;
  logic [RAW_W-1:0]          s1_d1;
  // stage 2
  logic signed [PROD_W-1:0]  s2_tprod;
  logic signed [PROD_W-1:0]  s2_oprod;
  logic signed [PROD_W-1:0]  s2_sprod;
  logic [RAW_W-1:0]          s2_d1;
  // stage 3
  logic signed [TEMP_W-1:0]  s3_temp;
  logic signed [OFF_W-1:0]   s3_off;
  logic signed [SENS_W-1:0]  s3_sens;
  logic [RAW_W-1:0]          s3_d1;
  // stage 4
  logic [PP_LO_W-1:0]        s4_pp_lo;
  logic signed [PP_HI_W-1:0] s4_pp_hi;
  logic signed [TEMP_W-1:0]  s4_temp;
  logic signed [OFF_W-1:0]   s4_off;
  // stage 5
  logic signed [PSH_W-1:0]   s5_psh;
  logic signed [TEMP_W-1:0]  s5_temp;
  logic signed [OFF_W-1:0]   s5_off;

  // combinational helpers
  logic signed [DT_W-1:0]    dt_c;
  logic signed [PROD_W-1:0]  tbias_c;
  logic signed [PROD_W-1:0]  tsum_c;
  logic signed [OFF_W-1:0]   off_c;
  logic signed [SENS_W-1:0]  sens_c;
  logic signed [FULL_W-1:0]  full_c;
  logic signed [DIFF_W-1:0]  diff_c;

  assign dt_c = $signed({1'b0, raw_temperature})
              - $signed({1'b0, coeff.ref_temp, {REF_SHIFT{1'b0}}});

  // truncation toward zero: bias negative products before the shift
  assign tbias_c = s2_tprod[PROD_W-1] ? PROD_W'((64'd1 << TEMP_SHIFT) - 64'd1) : '0;
  assign tsum_c = s2_tprod + tbias_c;

  assign off_c = $signed(OFF_W'({coeff.offset, {OFF_BASE_SHIFT{1'b0}}}))
               + OFF_W'($signed(s2_oprod[PROD_W-1:OFF_TC_SHIFT]));
  assign sens_c = $signed(SENS_W'({coeff.sens, {SENS_BASE_SHIFT{1'b0}}}))
                + SENS_W'($signed(s2_sprod[PROD_W-1:SENS_TC_SHIFT]));

  assign full_c = (FULL_W'(s4_pp_hi) <<< SENS_LO_W)
                + $signed(FULL_W'({1'b0, s4_pp_lo}));

  assign diff_c = DIFF_W'(s5_psh) - DIFF_W'(s5_off);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_dt <= dt_c;
      s1_d1 <= pressure_adc;
    end
    if (en[1]) begin
      s2_tprod <= s1_dt * $signed({1'b0, coeff.temp_slope});
      s2_oprod <= s1_dt * $signed({1'b0, coeff.offset_temp});
      s2_sprod <= s1_dt * $signed({1'b0, coeff.sens_temp});
      s2_d1 <= s1_d1;
    end
    if (en[2]) begin
      s3_temp <= TEMP_BASE + $signed(tsum_c[PROD_W-1:TEMP_SHIFT]);
      s3_off <= off_c;
      s3_sens <= sens_c;
      s3_d1 <= s2_d1;
    end
    if (en[3]) begin
      s4_pp_lo <= s3_d1 * s3_sens[SENS_LO_W-1:0];
      s4_pp_hi <= $signed({1'b0, s3_d1}) * $signed(s3_sens[SENS_W-1:SENS_LO_W]);
      s4_temp <= s3_temp;
      s4_off <= s3_off;
    end
    if (en[4]) begin
      s5_psh <= $signed(full_c[FULL_W-1:PRESS_MUL_SHIFT]);
      s5_temp <= s4_temp;
      s5_off <= s4_off;
    end
    if (en[5]) begin
      temperature_centi <= s5_temp;
      pressure_pa <= $signed(diff_c[PRESS_OUT_SHIFT+PRESS_W-1:PRESS_OUT_SHIFT]);
    end
  end

endmodule

FILE: hw/rtl/baro_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// baro_pressure_compensation_core
// pipeline: six register stages; a request enters stage 1 when accepted
//   and moves through stages 2 to 5 into the output register of stage 6
// throughput: one request per cycle unless out_stall fills the pipe; the dt
//   products and split pressure multiply own a stage each; nothing iterates
// reset: synchronous, clears the calibration words and all valid bits
// ----------------------------------------------------------------------------
module baro_pressure_compensation_core import bpc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // apb configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // raw reading request
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [RAW_W-1:0]          raw_temperature,
  input  logic [RAW_W-1:0]          pressure_adc,
  // compensated result
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TEMP_W-1:0]  temperature_centi,
  output logic signed [PRESS_W-1:0] pressure_pa
);

  // user, not block, keeps calibration words stable while requests are in flight
  coeff_t coeff;

  // per-stage load enables from the control chain
  logic [NUM_STAGES-1:0] en;

  bpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coeff   (coeff)
  );

  // a bubble anywhere in the pipe lets the stages above it keep moving
  // even while the output request is held
  bpc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .en        (en)
  );

  // stage 1 subtracts the reference, stage 2 forms the three dt products,
  // stage 3 the temperature, offset and sensitivity, stage 4 splits the
  // 24 x 36 bit pressure product in two, stage 5 recombines and shifts,
  // stage 6 removes the offset into the output register
  bpc_datapath u_dp (
    .clk               (clk),
    .en                (en),
    .coeff             (coeff),
    .raw_temperature   (raw_temperature),
    .pressure_adc      (pressure_adc),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa)
  );

`ifndef SYNTH
  // input is only held back when the pipe is full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held output");

  // a free output never backs up into the input
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

  // compensated temperature stays inside its reachable span
  a_temp_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temperature_centi >= -19'sd129070 &&
                   temperature_centi <= 19'sd133070))
    else $error("temperature out of reachable range");
`endif

endmodule

FILE: tb/baro_compensation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_compensation_checker
// follows the calibration writes on the configuration port, predicts the
// compensated temperature and pressure of every accepted request, and checks
// results and register reads as they leave the block
// ----------------------------------------------------------------------------
module baro_compensation_checker import bpc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  input  logic [DATA_W-1:0]         prdata,
  input  logic                      pready,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [RAW_W-1:0]          raw_temperature,
  input  logic [RAW_W-1:0]          pressure_adc,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [TEMP_W-1:0]  temperature_centi,
  input  logic signed [PRESS_W-1:0] pressure_pa,
  output int unsigned               failures,
  output int unsigned               pending
);

  typedef struct packed {
    logic signed [TEMP_W-1:0]  temperature;
    logic signed [PRESS_W-1:0] pressure;
  } reading_t;

  coeff_t   calib;
  reading_t expected_readings[$];

  initial begin
    failures = 0;
    pending  = 0;
    calib    = '0;
  end

  task automatic report_failure(input string msg);
    $display("%0t ERROR %s", $time, msg);
    failures++;
  endtask

  // first-order compensation, 64-bit signed intermediates
  function automatic reading_t compensate(input logic [RAW_W-1:0] raw_t,
                                          input logic [RAW_W-1:0] raw_p,
                                          input coeff_t c);
    longint   dt, temp, off, sens, press;
    reading_t r;
    dt    = longint'(raw_t) - (longint'(c.ref_temp) <<< REF_SHIFT);
    // signed division truncates toward zero
    temp  = longint'(TEMP_BASE) + (dt * longint'(c.temp_slope)) / (longint'(1) <<< TEMP_SHIFT);
    // the remaining steps floor through arithmetic shifts
    off   = (longint'(c.offset) <<< OFF_BASE_SHIFT)
          + ((longint'(c.offset_temp) * dt) >>> OFF_TC_SHIFT);
    sens  = (longint'(c.sens) <<< SENS_BASE_SHIFT)
          + ((longint'(c.sens_temp) * dt) >>> SENS_TC_SHIFT);
    press = (((longint'(raw_p) * sens) >>> PRESS_MUL_SHIFT) - off) >>> PRESS_OUT_SHIFT;
    r.temperature = temp[TEMP_W-1:0];
    r.pressure    = press[PRESS_W-1:0];
    return r;
  endfunction

  // -1 marks an unmapped index
  function automatic int calib_word(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_SENS:        return int'(calib.sens);
      REG_OFFSET:      return int'(calib.offset);
      REG_SENS_TEMP:   return int'(calib.sens_temp);
      REG_OFFSET_TEMP: return int'(calib.offset_temp);
      REG_REF_TEMP:    return int'(calib.ref_temp);
      REG_TEMP_SLOPE:  return int'(calib.temp_slope);
      default:         return -1;
    endcase
  endfunction

  always @(posedge clk) begin
    logic [REG_IDX_W-1:0] idx;
    int                   word;
    reading_t             want;
    if (rst) begin
      calib = '0;
      expected_readings.delete();
      pending <= 0;
    end else begin
      idx = paddr[ADDR_W-1:2];
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (idx)
            REG_SENS:        calib.sens        = pwdata[COEFF_W-1:0];
            REG_OFFSET:      calib.offset      = pwdata[COEFF_W-1:0];
            REG_SENS_TEMP:   calib.sens_temp   = pwdata[COEFF_W-1:0];
            REG_OFFSET_TEMP: calib.offset_temp = pwdata[COEFF_W-1:0];
            REG_REF_TEMP:    calib.ref_temp    = pwdata[COEFF_W-1:0];
            REG_TEMP_SLOPE:  calib.temp_slope  = pwdata[COEFF_W-1:0];
            default: ;
          endcase
        end else begin
          word = calib_word(idx);
          if (word >= 0 && prdata !== DATA_W'(word))
            report_failure($sformatf("register %0d read back %h, expected %h",
                                     idx, prdata, DATA_W'(word)));
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(compensate(raw_temperature, pressure_adc, calib));
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_failure($sformatf("result %0d / %0d with no request outstanding",
                                   temperature_centi, pressure_pa));
        end else begin
          want = expected_readings.pop_front();
          if (temperature_centi !== want.temperature)
            report_failure($sformatf("temperature_centi %0d, expected %0d",
                                     temperature_centi, want.temperature));
          if (pressure_pa !== want.pressure)
            report_failure($sformatf("pressure_pa %0d, expected %0d",
                                     pressure_pa, want.pressure));
        end
      end
      pending <= expected_readings.size();
    end
  end

endmodule

FILE: tb/tb_baro_pressure_compensation_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_pressure_compensation_core
// drives calibration words and raw reading requests into the compensation
// core, with random gaps on both channels and one long output hold-off; a
// checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_baro_pressure_compensation_core;
  import bpc_pkg::*;

  localparam int SEGMENTS          = 6;
  localparam int SEGMENT_REQUESTS  = 330;
  localparam int LONG_HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES     = 16;
  localparam int RESET_CYCLES      = 12;
  localparam longint TIMEOUT_NS    = 2_000_000;

  // unmapped register slots, writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  logic                      clk     = 1'b0;
  logic                      rst     = 1'b1;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [ADDR_W-1:0]         paddr   = '0;
  logic [DATA_W-1:0]         pwdata  = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid        = 1'b0;
  logic                      in_stall;
  logic [RAW_W-1:0]          raw_temperature = '0;
  logic [RAW_W-1:0]          pressure_adc    = '0;
  logic                      out_valid;
  logic                      out_stall       = 1'b0;
  logic signed [TEMP_W-1:0]  temperature_centi;
  logic signed [PRESS_W-1:0] pressure_pa;

  int unsigned failures;
  int unsigned pending;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct  = 10;
  int unsigned recv_stall_pct = 73;

  // long hold-off handshake between stimulus and the result drain
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;

  // calibration as last loaded, used to aim temperatures near the reference
  coeff_t loaded_calib = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  baro_pressure_compensation_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .raw_temperature   (raw_temperature),
    .pressure_adc      (pressure_adc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa)
  );

  baro_compensation_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .raw_temperature   (raw_temperature),
    .pressure_adc      (pressure_adc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .pressure_pa       (pressure_pa),
    .failures          (failures),
    .pending           (pending)
  );

  // apb write: setup cycle, then access until pready
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] word);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    // junk in the upper half, only the low 16 bits count
    pwdata  <= {16'($urandom), word};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // apb read, the checker compares prdata at the access edge
  task automatic apb_read(input logic [REG_IDX_W-1:0] idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back_all();
    apb_read(REG_SENS);
    apb_read(REG_OFFSET);
    apb_read(REG_SENS_TEMP);
    apb_read(REG_OFFSET_TEMP);
    apb_read(REG_REF_TEMP);
    apb_read(REG_TEMP_SLOPE);
  endtask

  // every request gives a result, so an empty queue means the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_calibration(input coeff_t c);
    wait_idle();
    apb_write(REG_SENS, c.sens);
    apb_write(REG_OFFSET, c.offset);
    apb_write(REG_SENS_TEMP, c.sens_temp);
    apb_write(REG_OFFSET_TEMP, c.offset_temp);
    apb_write(REG_REF_TEMP, c.ref_temp);
    apb_write(REG_TEMP_SLOPE, c.temp_slope);
    read_back_all();
    loaded_calib = c;
  endtask

  // one raw reading request, with an optional gap of noise before it
  task automatic send_request(input logic [RAW_W-1:0] t, input logic [RAW_W-1:0] p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        raw_temperature <= RAW_W'($urandom);
        pressure_adc    <= RAW_W'($urandom);
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    raw_temperature <= t;
    pressure_adc    <= p;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [COEFF_W-1:0] pick_coeff_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return COEFF_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic coeff_t random_calibration();
    coeff_t c;
    c.sens        = pick_coeff_word();
    c.offset      = pick_coeff_word();
    c.sens_temp   = pick_coeff_word();
    c.offset_temp = pick_coeff_word();
    c.ref_temp    = pick_coeff_word();
    c.temp_slope  = pick_coeff_word();
    return c;
  endfunction

  // temperatures cluster around the reference so dt changes sign often
  function automatic logic [RAW_W-1:0] pick_raw_temperature();
    case ($urandom_range(9))
      0:          return '0;
      1:          return RAW_MAX;
      2, 3, 4, 5: return RAW_W'({loaded_calib.ref_temp, 8'h00} + $urandom_range(4095) - 2048);
      default:    return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_pressure_adc();
    case ($urandom_range(9))
      0:       return '0;
      1:       return RAW_MAX;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // result drain: random stalls, or one long hold-off when asked
  initial begin : result_drain
    int unsigned held;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall <= 1'b1;
        for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    coeff_t c;
    int     seg;
    int     n;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset calibration is all zero: temperature sits at base, pressure at zero
    read_back_all();
    send_request('0, '0);
    send_request(RAW_MAX, RAW_MAX);

    // every word at its maximum
    c = '1;
    load_calibration(c);
    send_request('0, '0);
    send_request('0, RAW_MAX);
    send_request(RAW_MAX, '0);
    send_request(RAW_MAX, RAW_MAX);
    // dt of zero, then dt of minus one: truncation and floor part ways
    send_request({c.ref_temp, 8'h00}, 24'h800000);
    send_request({c.ref_temp, 8'h00} - 1'b1, RAW_MAX);
    send_request({c.ref_temp, 8'h00} + 1'b1, 24'h123456);

    // reference at zero, so dt never goes negative
    c.ref_temp = '0;
    load_calibration(c);
    send_request(RAW_MAX, RAW_MAX);
    send_request('0, RAW_MAX);
    send_request(24'h000001, RAW_MAX);

    // datasheet-like calibration and readings
    c = '{sens: 16'd40127, offset: 16'd36924, sens_temp: 16'd23317,
          offset_temp: 16'd23282, ref_temp: 16'd33464, temp_slope: 16'd28312};
    load_calibration(c);
    send_request(24'd9085466, 24'd9085466);
    send_request(24'd8569150, 24'd8077636);
    send_request(24'd8000000, 24'd6000000);

    // unmapped slots take the write and change nothing
    wait_idle();
    apb_write(REG_SPARE_LO, 16'hA5A5);
    apb_write(REG_SPARE_HI, 16'h5A5A);
    read_back_all();
    send_request(24'd8569150, 24'd8077636);

    // random part: two segments per idling phase, fresh calibration each
    for (seg = 0; seg < SEGMENTS; seg++) begin
      load_calibration(random_calibration());
      case (seg / 2)
        0: begin
          send_idle_pct  = 10;
          recv_stall_pct = 73;
        end
        1: begin
          send_idle_pct  = 73;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      // sender keeps pushing through a long hold-off so the pipe backs up
      if (seg == 4) holds_asked <= holds_asked + 1;
      for (n = 0; n < SEGMENT_REQUESTS; n++)
        send_request(pick_raw_temperature(), pick_pressure_adc());
    end

    // drain, then let the pipe settle past its latency
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // hard stop if anything hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_regs.sv
hw/rtl/bpc_pipe_ctrl.sv
hw/rtl/bpc_datapath.sv
hw/rtl/baro_pressure_compensation_core.sv
tb/baro_compensation_checker.sv
tb/tb_baro_pressure_compensation_core.sv
